### rtl/core/rott_pkg.sv
// ----------------------------------------------------------------------------
// rott_pkg: shared types and codes for the recency-ordered thread table
// Request kinds, result status codes, fixed field widths and the control
// bundle that the top level hands to each cell of the row.
// ----------------------------------------------------------------------------
package rott_pkg;

  // Request kind, carried in tuser
  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_READ = 1'b1
  } mode_t;

  // Result status
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DROPPED = 2'd1,
    ST_REFUSED = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // Fixed field widths of the stream payloads
  localparam int unsigned PORT_KEY_W   = 64;
  localparam int unsigned RANK_W       = 3;
  localparam int unsigned SLOT_W       = 4;
  localparam int unsigned OUT_COUNT_W  = 5;
  localparam int unsigned IN_TDATA_W   = 72;
  localparam int unsigned OUT_TDATA_W  = 80;

  // Per-cell control from the top level
  typedef struct packed {
    logic in_use;       // this rank holds a thread
    logic prev_in_use;  // the rank above holds a thread (always set for rank 0)
    logic rank_sel;     // this rank is the one a read asks for
    logic read;         // current request is a read
    logic commit;       // a push is taken and changes the table this cycle
    logic found;        // the pushed key matched some thread
  } cell_ctl_t;

endpackage

### rtl/core/rott_cell.sv
// ----------------------------------------------------------------------------
// rott_cell: one rank of the thread table
// Holds one key and its message count, matches the probe key, forwards the
// picked entry toward rank 0 and takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module rott_cell #(
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned COUNT_BITS = 5
) (
  input  logic                  clk,
  input  rott_pkg::cell_ctl_t   ctl,
  input  logic [KEY_BITS-1:0]   probe_key,
  // entry from the rank above (new entry for rank 0)
  input  logic [KEY_BITS-1:0]   prev_key,
  input  logic [COUNT_BITS-1:0] prev_count,
  // chain from the deeper ranks
  input  logic                  seen_in,
  input  logic                  pick_any_in,
  input  logic [KEY_BITS-1:0]   pick_key_in,
  input  logic [COUNT_BITS-1:0] pick_count_in,
  // chain toward rank 0
  output logic                  seen_out,
  output logic                  pick_any_out,
  output logic [KEY_BITS-1:0]   pick_key_out,
  output logic [COUNT_BITS-1:0] pick_count_out,
  // stored entry, handed to the rank below on a shift
  output logic [KEY_BITS-1:0]   key,
  output logic [COUNT_BITS-1:0] count
);

  logic hit;
  logic pick;
  logic shift;

  always_comb begin
    hit            = ctl.in_use && (key == probe_key);
    pick           = ctl.read ? (ctl.rank_sel && ctl.in_use) : hit;
    seen_out       = hit | seen_in;
    pick_any_out   = pick | pick_any_in;
    pick_key_out   = pick_key_in | (pick ? key : '0);
    pick_count_out = pick_count_in | (pick ? count : '0);
    // ranks at or above the touched thread move down one place
    shift          = ctl.commit && (ctl.found ? seen_out : ctl.prev_in_use);
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key   <= prev_key;
      count <= prev_count;
    end
  end

endmodule

### rtl/core/recency_ordered_thread_table.sv
// ----------------------------------------------------------------------------
// recency_ordered_thread_table: move-to-front table of message threads
// Matches pushed phone keys against a row of cells, counts messages per
// thread and returns rank, body slot and count; reads a thread by rank.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel. tuser selects the kind: push a
//   message (match the key, open or bump the thread, move it to rank 0) or
//   read the thread at query_rank. Every request gives exactly one result on
//   the m_axis channel, carrying status, rank, message slot, direction, key
//   and count; external memory stores the body at the returned slot.
//   The result sits in the output register on the edge after the request
//   is taken. Throughput is one request per cycle while the receiver takes
//   results, set by the compare, pick and shift across the row of THREADS
//   cells (the pick and match chains run through every cell).
//   s_axis_tready is high while the output register is empty or being taken,
//   so a stalled receiver holds one result and stalls the sender after it.
//   Reset empties the table (thread count to zero) and the output register;
//   the cell contents are not cleared, as only ranks in use are ever read.
// ----------------------------------------------------------------------------
module recency_ordered_thread_table #(
  parameter int unsigned THREADS             = 8,
  parameter int unsigned MESSAGES_PER_THREAD = 16,
  parameter int unsigned KEY_BITS            = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [63:0] phone_key, [64] direction, [67:65] query_rank, [71:68] zero
  input  logic [rott_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] mode
  input  logic [0:0]                         s_axis_tuser,
  // result channel
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] status, [4:2] thread_rank, [8:5] message_slot, [9] direction_out,
  // [73:10] thread_key, [78:74] message_count, [79] zero
  output logic [rott_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned COUNT_BITS = $clog2(MESSAGES_PER_THREAD + 1);
  localparam int unsigned USED_W     = $clog2(THREADS + 1);

  // Request fields
  logic                          req_read;
  logic [rott_pkg::PORT_KEY_W-1:0] req_key;
  logic                          req_dir;
  logic [rott_pkg::RANK_W-1:0]   req_rank;
  logic [KEY_BITS-1:0]           probe_key;

  // Table occupancy
  logic [USED_W-1:0]             used;
  logic [USED_W-1:0]             used_next;

  // Cell row wiring
  rott_pkg::cell_ctl_t           cell_ctl   [THREADS];
  logic [KEY_BITS-1:0]           cell_key   [THREADS];
  logic [COUNT_BITS-1:0]         cell_count [THREADS];
  logic [KEY_BITS-1:0]           prev_key   [THREADS];
  logic [COUNT_BITS-1:0]         prev_count [THREADS];
  logic                          seen_ch    [THREADS+1];
  logic                          pany_ch    [THREADS+1];
  logic [KEY_BITS-1:0]           pkey_ch    [THREADS+1];
  logic [COUNT_BITS-1:0]         pcount_ch  [THREADS+1];

  // Push decision
  logic                          accept;
  logic                          found;
  logic                          full;
  logic                          refuse;
  logic                          room;
  logic                          commit;
  logic [COUNT_BITS-1:0]         base_count;
  logic [COUNT_BITS-1:0]         new_count;
  logic [COUNT_BITS-1:0]         slot;

  // Output register
  logic                          out_valid;
  rott_pkg::status_t             out_status;
  logic [rott_pkg::RANK_W-1:0]   out_rank;
  logic [rott_pkg::SLOT_W-1:0]   out_slot;
  logic                          out_dir;
  logic [rott_pkg::PORT_KEY_W-1:0] out_key;
  logic [rott_pkg::OUT_COUNT_W-1:0] out_count;
  rott_pkg::status_t             res_status;
  logic [rott_pkg::RANK_W-1:0]   res_rank;
  logic [rott_pkg::SLOT_W-1:0]   res_slot;
  logic                          res_dir;
  logic [rott_pkg::PORT_KEY_W-1:0] res_key;
  logic [rott_pkg::OUT_COUNT_W-1:0] res_count;

  assign req_read  = (rott_pkg::mode_t'(s_axis_tuser[0]) == rott_pkg::MODE_READ);
  assign req_key   = s_axis_tdata[63:0];
  assign req_dir   = s_axis_tdata[64];
  assign req_rank  = s_axis_tdata[67:65];
  assign probe_key = req_key[KEY_BITS-1:0];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Chain ends: nothing seen below the last rank
  assign seen_ch[THREADS]   = 1'b0;
  assign pany_ch[THREADS]   = 1'b0;
  assign pkey_ch[THREADS]   = '0;
  assign pcount_ch[THREADS] = '0;

  // Row of cells, rank 0 at index 0
  for (genvar i = 0; i < THREADS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_key[i]   = probe_key;
      assign prev_count[i] = new_count;
      assign cell_ctl[i].prev_in_use = 1'b1;
    end else begin : g_body
      assign prev_key[i]   = cell_key[i-1];
      assign prev_count[i] = cell_count[i-1];
      assign cell_ctl[i].prev_in_use = ((i - 1) < int'(used));
    end
    assign cell_ctl[i].in_use   = (i < int'(used));
    assign cell_ctl[i].rank_sel = (int'(req_rank) == i);
    assign cell_ctl[i].read     = req_read;
    assign cell_ctl[i].commit   = commit;
    assign cell_ctl[i].found    = found;

    rott_cell #(
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk            (clk),
      .ctl            (cell_ctl[i]),
      .probe_key      (probe_key),
      .prev_key       (prev_key[i]),
      .prev_count     (prev_count[i]),
      .seen_in        (seen_ch[i+1]),
      .pick_any_in    (pany_ch[i+1]),
      .pick_key_in    (pkey_ch[i+1]),
      .pick_count_in  (pcount_ch[i+1]),
      .seen_out       (seen_ch[i]),
      .pick_any_out   (pany_ch[i]),
      .pick_key_out   (pkey_ch[i]),
      .pick_count_out (pcount_ch[i]),
      .key            (cell_key[i]),
      .count          (cell_count[i])
    );
  end

  // Push: keys are unique in the table, so at most one cell matches
  always_comb begin
    found      = seen_ch[0];
    full       = (used == USED_W'(THREADS));
    refuse     = !found && full;
    base_count = found ? pcount_ch[0] : '0;
    room       = (base_count < COUNT_BITS'(MESSAGES_PER_THREAD));
    new_count  = room ? COUNT_BITS'(base_count + 1'b1) : base_count;
    slot       = room ? base_count : '0;
    commit     = accept && !req_read && !refuse;
    used_next  = (commit && !found) ? USED_W'(used + 1'b1) : used;
  end

  // Result assembly
  always_comb begin
    if (req_read) begin
      res_status = pany_ch[0] ? rott_pkg::ST_OK : rott_pkg::ST_EMPTY;
      res_rank   = req_rank;
      res_slot   = '0;
      res_dir    = 1'b0;
      res_key    = rott_pkg::PORT_KEY_W'(pkey_ch[0]);
      res_count  = rott_pkg::OUT_COUNT_W'(pcount_ch[0]);
    end else if (refuse) begin
      res_status = rott_pkg::ST_REFUSED;
      res_rank   = '0;
      res_slot   = '0;
      res_dir    = req_dir;
      res_key    = '0;
      res_count  = '0;
    end else begin
      res_status = room ? rott_pkg::ST_OK : rott_pkg::ST_DROPPED;
      res_rank   = '0;
      res_slot   = rott_pkg::SLOT_W'(slot);
      res_dir    = req_dir;
      res_key    = rott_pkg::PORT_KEY_W'(probe_key);
      res_count  = rott_pkg::OUT_COUNT_W'(new_count);
    end
  end

  // Occupancy and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      used <= used_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= res_status;
      out_rank   <= res_rank;
      out_slot   <= res_slot;
      out_dir    <= res_dir;
      out_key    <= res_key;
      out_count  <= res_count;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_count, out_key, out_dir, out_slot, out_rank,
                          out_status};

  // Occupancy never runs past the row
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(THREADS))
    else $error("thread count exceeds table size");

  // Opening a thread adds exactly one to the occupancy
  a_open_grows: assert property (@(posedge clk) disable iff (rst)
    commit && !found |=> used == $past(used) + 1'b1)
    else $error("new thread did not grow occupancy");

  // Refused push and reads leave occupancy alone
  a_no_change: assert property (@(posedge clk) disable iff (rst)
    accept && (req_read || refuse) |=> $stable(used))
    else $error("occupancy changed without a new thread");

  // An empty output register never blocks requests
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_axis_tready)
    else $error("request stalled with empty output");

  // A refused push only happens on a full table
  a_refuse_full: assert property (@(posedge clk) disable iff (rst)
    accept && !req_read && refuse |-> used == USED_W'(THREADS))
    else $error("push refused with free rank");

endmodule
